>>> rtl/ita_pkg.sv
package ita_pkg;

    localparam int VALUE_W    = 32;
    localparam int DIGIT_W    = 4;
    localparam int NUM_CELLS  = 10;
    localparam int HEX_DIGITS = VALUE_W / DIGIT_W;
    localparam int CNT_W      = $clog2(NUM_CELLS + 1);
    localparam int IDX_W      = $clog2(NUM_CELLS);
    localparam int CONV_W     = $clog2(VALUE_W);
    localparam int WIDTH_W    = 6;
    localparam int MAX_WIDTH  = 32;
    localparam int CHAR_W     = 8;
    localparam int DEC_RADIX  = 10;
    localparam int DABBLE_MIN = 5;
    localparam int DABBLE_ADD = 3;

    localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_MINUS   = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;

    typedef enum logic [1:0] {
        FUNC_SDEC      = 2'd0,
        FUNC_UDEC      = 2'd1,
        FUNC_HEX_LOWER = 2'd2,
        FUNC_HEX_UPPER = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_LOAD   = 2'd1,
        CELL_DABBLE = 2'd2
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     hex;
    } row_ctrl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SETUP,
        ST_SIGN_LEAD,
        ST_PAD_LEFT,
        ST_SIGN,
        ST_DIGITS,
        ST_PAD_RIGHT
    } state_t;

endpackage

>>> rtl/ita_cell.sv
// One digit of the row: load a nibble, or adjust by three and shift one bit up.
module ita_cell (
    input  logic                        aclk,
    input  ita_pkg::cell_op_t           op,
    input  logic [ita_pkg::DIGIT_W-1:0] load_digit,
    input  logic                        carry_in,
    output logic [ita_pkg::DIGIT_W-1:0] digit,
    output logic                        carry_out
);

    logic [ita_pkg::DIGIT_W-1:0] digit_reg;
    logic [ita_pkg::DIGIT_W-1:0] digit_next;
    logic [ita_pkg::DIGIT_W-1:0] adj;

    assign adj = (digit_reg >= ita_pkg::DIGIT_W'(ita_pkg::DABBLE_MIN))
               ? digit_reg + ita_pkg::DIGIT_W'(ita_pkg::DABBLE_ADD) : digit_reg;
    assign carry_out = adj[ita_pkg::DIGIT_W-1];
    assign digit     = digit_reg;

    always_comb begin
        unique case (op)
            ita_pkg::CELL_LOAD:   digit_next = load_digit;
            ita_pkg::CELL_DABBLE: digit_next = {adj[ita_pkg::DIGIT_W-2:0], carry_in};
            default:              digit_next = digit_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        digit_reg <= digit_next;
    end

endmodule

>>> rtl/ita_digit_row.sv
// Row of digit cells fed MSB first from a shift register; picks one digit for output.
module ita_digit_row (
    input  logic                        aclk,
    input  ita_pkg::row_ctrl_t          ctrl,
    input  logic [ita_pkg::VALUE_W-1:0] load_value,
    input  logic [ita_pkg::IDX_W-1:0]   sel_idx,
    output logic [ita_pkg::DIGIT_W-1:0] sel_digit,
    output logic [ita_pkg::CNT_W-1:0]   digit_count
);

    logic [ita_pkg::VALUE_W-1:0] feed_reg;
    logic [ita_pkg::VALUE_W-1:0] feed_next;
    logic [ita_pkg::NUM_CELLS:0] carry;
    logic [ita_pkg::DIGIT_W-1:0] digit   [ita_pkg::NUM_CELLS];
    logic [ita_pkg::DIGIT_W-1:0] load_dg [ita_pkg::NUM_CELLS];

    assign carry[0] = feed_reg[ita_pkg::VALUE_W-1];

    always_comb begin
        unique case (ctrl.op)
            ita_pkg::CELL_LOAD:   feed_next = load_value;
            ita_pkg::CELL_DABBLE: feed_next = {feed_reg[ita_pkg::VALUE_W-2:0], 1'b0};
            default:              feed_next = feed_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        feed_reg <= feed_next;
    end

    for (genvar i = 0; i < ita_pkg::NUM_CELLS; i++) begin : g_cell
        if (i < ita_pkg::HEX_DIGITS) begin : g_nib
            assign load_dg[i] = ctrl.hex ? load_value[i*ita_pkg::DIGIT_W +: ita_pkg::DIGIT_W]
                                         : '0;
        end else begin : g_zero
            assign load_dg[i] = '0;
        end

        ita_cell u_cell (
            .aclk       (aclk),
            .op         (ctrl.op),
            .load_digit (load_dg[i]),
            .carry_in   (carry[i]),
            .digit      (digit[i]),
            .carry_out  (carry[i+1])
        );
    end

    // Highest nonzero digit sets the count; zero still prints one digit.
    always_comb begin
        digit_count = ita_pkg::CNT_W'(1);
        for (int i = 0; i < ita_pkg::NUM_CELLS; i++) begin
            if (digit[i] != '0) begin
                digit_count = ita_pkg::CNT_W'(i + 1);
            end
        end
    end

    always_comb begin
        sel_digit = '0;
        for (int i = 0; i < ita_pkg::NUM_CELLS; i++) begin
            if (sel_idx == ita_pkg::IDX_W'(i)) begin
                sel_digit = digit[i];
            end
        end
    end

endmodule

>>> rtl/integer_to_ascii_formatter_unit.sv
// Integer to ASCII formatter: printf-style %d, %u, %x and %X with width and pad flags.
//
// Input channel (s_): one word per value. s_tuser carries the format selector,
// s_tdata the value, the field width and the pad flags. A word is taken only while
// the unit is idle, one value at a time.
// Result channel (m_): one word per character, left to right; m_tlast marks the
// final character of the field.
//
// Flow: decimal formats run the value MSB first through a row of ten BCD digit
// cells, one bit per cycle (shift-and-add-three); hex loads the nibbles straight
// into the cells and skips that conversion. A setup state then sizes the padding.
// After that one character leaves per cycle while m_tready does not stall the
// output. All n characters of a field (n at most 32 with padding) leave before the
// unit returns to idle and takes the next value.
//
// Reset (aresetn low, synchronous) returns the control to idle and drops any
// pending result word. A stall on m_tready holds the current result word and
// freezes character generation; nothing is lost or repeated.
module integer_to_ascii_formatter_unit (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // value [31:0], field_width [37:32], pad_mode [39:38]
    input  logic [1:0]  s_tuser,   // func [1:0]

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // ascii_char [7:0]
    output logic        m_tlast    // last_char
);

    ita_pkg::state_t state_reg, state_next;

    ita_pkg::func_t                 func_reg, func_next;
    logic                           neg_reg, neg_next;
    logic                           pad_right_reg, pad_right_next;
    logic                           pad_zero_reg, pad_zero_next;
    logic [ita_pkg::WIDTH_W-1:0]    width_reg, width_next;
    logic [ita_pkg::CONV_W-1:0]     conv_cnt_reg, conv_cnt_next;
    logic [ita_pkg::IDX_W-1:0]      idx_reg, idx_next;
    logic [ita_pkg::WIDTH_W-1:0]    pad_cnt_reg, pad_cnt_next;

    logic                           m_tvalid_reg, m_tvalid_next;
    logic [ita_pkg::CHAR_W-1:0]     m_tdata_reg, m_tdata_next;
    logic                           m_tlast_reg, m_tlast_next;

    // Input word fields.
    ita_pkg::func_t                 func_in;
    logic [ita_pkg::VALUE_W-1:0]    value_in;
    logic [ita_pkg::WIDTH_W-1:0]    fw_in;
    logic [1:0]                     pad_in;
    logic                           neg_in;

    // Digit row interface.
    ita_pkg::row_ctrl_t             row_ctrl;
    logic [ita_pkg::VALUE_W-1:0]    mag;
    logic [ita_pkg::DIGIT_W-1:0]    sel_digit;
    logic [ita_pkg::CNT_W-1:0]      digit_count;

    // Field layout.
    logic                           sign_lead;
    logic                           sign_inline;
    logic [ita_pkg::WIDTH_W-1:0]    width_eff;
    logic [ita_pkg::WIDTH_W-1:0]    text_len;
    logic [ita_pkg::WIDTH_W-1:0]    pad_total;
    logic [ita_pkg::CHAR_W-1:0]     pad_char;
    logic [ita_pkg::CHAR_W-1:0]     letter_base;
    logic [ita_pkg::CHAR_W-1:0]     digit_char;
    logic                           right_pending;

    logic                           out_ready;
    logic                           emit_valid;
    logic [ita_pkg::CHAR_W-1:0]     emit_char;
    logic                           emit_last;
    logic                           emit_fire;

    assign func_in  = ita_pkg::func_t'(s_tuser);
    assign value_in = s_tdata[31:0];
    assign fw_in    = s_tdata[37:32];
    assign pad_in   = s_tdata[39:38];
    assign neg_in   = (func_in == ita_pkg::FUNC_SDEC) && value_in[ita_pkg::VALUE_W-1];
    assign mag      = neg_in ? (ita_pkg::VALUE_W'(0) - value_in) : value_in;

    ita_digit_row u_row (
        .aclk        (aclk),
        .ctrl        (row_ctrl),
        .load_value  (mag),
        .sel_idx     (idx_reg),
        .sel_digit   (sel_digit),
        .digit_count (digit_count)
    );

    // A leading sign takes a column of the width and goes ahead of zero padding.
    assign sign_lead   = neg_reg && (width_reg != '0) && pad_zero_reg;
    assign sign_inline = neg_reg && !sign_lead;
    assign width_eff   = width_reg - ita_pkg::WIDTH_W'(sign_lead);
    assign text_len    = ita_pkg::WIDTH_W'(digit_count) + ita_pkg::WIDTH_W'(sign_inline);
    assign pad_total   = (width_eff > text_len) ? (width_eff - text_len) : '0;

    assign pad_char    = pad_zero_reg ? ita_pkg::CHAR_ZERO : ita_pkg::CHAR_SPACE;
    assign letter_base = (func_reg == ita_pkg::FUNC_HEX_UPPER) ? ita_pkg::CHAR_UPPER_A
                                                               : ita_pkg::CHAR_LOWER_A;
    assign digit_char  = (sel_digit < ita_pkg::DIGIT_W'(ita_pkg::DEC_RADIX))
                       ? ita_pkg::CHAR_ZERO + ita_pkg::CHAR_W'(sel_digit)
                       : letter_base + ita_pkg::CHAR_W'(sel_digit)
                         - ita_pkg::CHAR_W'(ita_pkg::DEC_RADIX);

    assign right_pending = pad_right_reg && (pad_cnt_reg != '0);
    assign out_ready     = !m_tvalid_reg || m_tready;
    assign emit_fire     = emit_valid && out_ready;

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ita_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    if (func_in == ita_pkg::FUNC_HEX_LOWER ||
                        func_in == ita_pkg::FUNC_HEX_UPPER) begin
                        state_next = ita_pkg::ST_SETUP;
                    end else begin
                        state_next = ita_pkg::ST_CONV;
                    end
                end
            end
            ita_pkg::ST_CONV: begin
                if (conv_cnt_reg == '0) begin
                    state_next = ita_pkg::ST_SETUP;
                end
            end
            ita_pkg::ST_SETUP: begin
                priority if (sign_lead) begin
                    state_next = ita_pkg::ST_SIGN_LEAD;
                end else if (!pad_right_reg && pad_total != '0) begin
                    state_next = ita_pkg::ST_PAD_LEFT;
                end else if (sign_inline) begin
                    state_next = ita_pkg::ST_SIGN;
                end else begin
                    state_next = ita_pkg::ST_DIGITS;
                end
            end
            ita_pkg::ST_SIGN_LEAD: begin
                if (out_ready) begin
                    if (!pad_right_reg && pad_cnt_reg != '0) begin
                        state_next = ita_pkg::ST_PAD_LEFT;
                    end else begin
                        state_next = ita_pkg::ST_DIGITS;
                    end
                end
            end
            ita_pkg::ST_PAD_LEFT: begin
                if (out_ready && pad_cnt_reg == ita_pkg::WIDTH_W'(1)) begin
                    state_next = sign_inline ? ita_pkg::ST_SIGN : ita_pkg::ST_DIGITS;
                end
            end
            ita_pkg::ST_SIGN: begin
                if (out_ready) begin
                    state_next = ita_pkg::ST_DIGITS;
                end
            end
            ita_pkg::ST_DIGITS: begin
                if (out_ready && idx_reg == '0) begin
                    state_next = right_pending ? ita_pkg::ST_PAD_RIGHT : ita_pkg::ST_IDLE;
                end
            end
            ita_pkg::ST_PAD_RIGHT: begin
                if (out_ready && pad_cnt_reg == ita_pkg::WIDTH_W'(1)) begin
                    state_next = ita_pkg::ST_IDLE;
                end
            end
            default: state_next = ita_pkg::ST_IDLE;
        endcase
    end

    // Outputs and datapath.
    always_comb begin
        s_tready       = 1'b0;
        row_ctrl.op    = ita_pkg::CELL_HOLD;
        row_ctrl.hex   = 1'b0;
        emit_valid     = 1'b0;
        emit_char      = ita_pkg::CHAR_SPACE;
        emit_last      = 1'b0;
        func_next      = func_reg;
        neg_next       = neg_reg;
        pad_right_next = pad_right_reg;
        pad_zero_next  = pad_zero_reg;
        width_next     = width_reg;
        conv_cnt_next  = conv_cnt_reg;
        idx_next       = idx_reg;
        pad_cnt_next   = pad_cnt_reg;

        unique case (state_reg)
            ita_pkg::ST_IDLE: begin
                s_tready     = 1'b1;
                row_ctrl.hex = (func_in == ita_pkg::FUNC_HEX_LOWER ||
                                func_in == ita_pkg::FUNC_HEX_UPPER);
                if (s_tvalid) begin
                    row_ctrl.op    = ita_pkg::CELL_LOAD;
                    func_next      = func_in;
                    neg_next       = neg_in;
                    pad_right_next = pad_in[0];
                    pad_zero_next  = pad_in[1];
                    width_next     = (fw_in > ita_pkg::WIDTH_W'(ita_pkg::MAX_WIDTH))
                                   ? ita_pkg::WIDTH_W'(ita_pkg::MAX_WIDTH) : fw_in;
                    conv_cnt_next  = ita_pkg::CONV_W'(ita_pkg::VALUE_W - 1);
                end
            end
            ita_pkg::ST_CONV: begin
                row_ctrl.op = ita_pkg::CELL_DABBLE;
                if (conv_cnt_reg != '0) begin
                    conv_cnt_next = conv_cnt_reg - ita_pkg::CONV_W'(1);
                end
            end
            ita_pkg::ST_SETUP: begin
                idx_next     = ita_pkg::IDX_W'(digit_count - ita_pkg::CNT_W'(1));
                pad_cnt_next = pad_total;
            end
            ita_pkg::ST_SIGN_LEAD, ita_pkg::ST_SIGN: begin
                emit_valid = 1'b1;
                emit_char  = ita_pkg::CHAR_MINUS;
            end
            ita_pkg::ST_PAD_LEFT, ita_pkg::ST_PAD_RIGHT: begin
                emit_valid = 1'b1;
                emit_char  = pad_char;
                emit_last  = pad_right_reg && (pad_cnt_reg == ita_pkg::WIDTH_W'(1));
                if (out_ready) begin
                    pad_cnt_next = pad_cnt_reg - ita_pkg::WIDTH_W'(1);
                end
            end
            ita_pkg::ST_DIGITS: begin
                emit_valid = 1'b1;
                emit_char  = digit_char;
                emit_last  = (idx_reg == '0) && !right_pending;
                if (out_ready && idx_reg != '0) begin
                    idx_next = idx_reg - ita_pkg::IDX_W'(1);
                end
            end
            default: begin
                emit_valid = 1'b0;
            end
        endcase
    end

    // Output register: load on a character, clear when taken.
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        priority if (emit_fire) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = emit_char;
            m_tlast_next  = emit_last;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ita_pkg::ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        func_reg      <= func_next;
        neg_reg       <= neg_next;
        pad_right_reg <= pad_right_next;
        pad_zero_reg  <= pad_zero_next;
        width_reg     <= width_next;
        conv_cnt_reg  <= conv_cnt_next;
        idx_reg       <= idx_next;
        pad_cnt_reg   <= pad_cnt_next;
        m_tdata_reg   <= m_tdata_next;
        m_tlast_reg   <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule
